[hdl/fvld_pkg.sv]
// Shared types, codes and helper functions for the vertex format layout decoder.
// Used by fvld_front, fvld_back, vertex_format_layout_decoder and the testbench. No dependencies.
package fvld_pkg;

    // Component kinds, as given on component_kind
    localparam logic [2:0] KIND_POS      = 3'd0;
    localparam logic [2:0] KIND_BLEND    = 3'd1;
    localparam logic [2:0] KIND_NORMAL   = 3'd2;
    localparam logic [2:0] KIND_PSIZE    = 3'd3;
    localparam logic [2:0] KIND_DIFFUSE  = 3'd4;
    localparam logic [2:0] KIND_SPECULAR = 3'd5;
    localparam logic [2:0] KIND_TEX      = 3'd6;

    // Number of fixed (non-texture) components; mask bit i is kind i
    localparam int unsigned NUM_FIXED = 6;

    // Position field codes (format code bits 3..1)
    localparam logic [2:0] POS_NONE    = 3'd0;
    localparam logic [2:0] POS_XYZRHW  = 3'd2;
    localparam logic [2:0] POS_XYZB1   = 3'd3;

    // Byte sizes of the fixed components
    localparam logic [4:0] SIZE_XYZ    = 5'd12;
    localparam logic [4:0] SIZE_XYZRHW = 5'd16;
    localparam logic [4:0] SIZE_NORMAL = 5'd12;
    localparam logic [4:0] SIZE_SCALAR = 5'd4;

    // One classified format code, as held in the queue
    typedef struct packed {
        logic                 reject;
        logic                 pre;
        logic [NUM_FIXED-1:0] mask;
        logic [4:0]           blend_size;
        logic [3:0]           tex_count;
        logic [7:0]           stride;
    } item_t;

    // Texture set width code to bytes: 0,1,2,3 -> 2,3,4,1 floats
    function automatic logic [4:0] tex_bytes(input logic [1:0] wcode);
        logic [4:0] bytes;
        unique case (wcode)
            2'd0:    bytes = 5'd8;
            2'd1:    bytes = 5'd12;
            2'd2:    bytes = 5'd16;
            default: bytes = 5'd4;
        endcase
        return bytes;
    endfunction

endpackage

[hdl/fvld_front.sv]
// Front end: classifies a format code into an item_t plus texture width codes.
// Depends on fvld_pkg.
module fvld_front #(
    parameter int MAX_TEX_SETS = 8
) (
    input  logic [31:0]                   format_code,
    output fvld_pkg::item_t               item,
    output logic [MAX_TEX_SETS-1:0][1:0]  tex_wcodes
);

    logic [2:0] pos;
    logic       pre;
    logic [3:0] count;
    logic       has_blend;
    logic [4:0] pos_size;
    logic [4:0] blend_size;
    logic [7:0] fixed_sum;
    logic [7:0] tex_sum;

    // Field extraction and sizes of position and blend weights
    always_comb
    begin
        pos        = format_code[3:1];
        pre        = (pos == fvld_pkg::POS_XYZRHW);
        count      = format_code[11:8];
        has_blend  = (pos >= fvld_pkg::POS_XYZB1);
        pos_size   = pre ? fvld_pkg::SIZE_XYZRHW : fvld_pkg::SIZE_XYZ;
        blend_size = has_blend ? {3'(pos - 3'd2), 2'b00} : 5'd0;
    end

    // Texture width codes for the sets this build supports
    always_comb
    begin
        for (int i = 0; i < MAX_TEX_SETS; i++)
        begin
            tex_wcodes[i] = format_code[16 + 2*i +: 2];
        end
    end

    // Stride: fixed components plus the texture sets in use
    always_comb
    begin
        fixed_sum = 8'(pos_size) + 8'(blend_size)
                  + (format_code[4] ? 8'(fvld_pkg::SIZE_NORMAL) : 8'd0)
                  + (format_code[5] ? 8'(fvld_pkg::SIZE_SCALAR) : 8'd0)
                  + (format_code[6] ? 8'(fvld_pkg::SIZE_SCALAR) : 8'd0)
                  + (format_code[7] ? 8'(fvld_pkg::SIZE_SCALAR) : 8'd0);
        tex_sum = 8'd0;
        for (int i = 0; i < MAX_TEX_SETS; i++)
        begin
            if (4'(i) < count)
            begin
                tex_sum = tex_sum + 8'(fvld_pkg::tex_bytes(format_code[16 + 2*i +: 2]));
            end
        end
    end

    // Classified item
    always_comb
    begin
        item.reject     = (pos == fvld_pkg::POS_NONE)
                        || (format_code[4] && pre)
                        || (count > 4'(MAX_TEX_SETS));
        item.pre        = pre;
        item.mask       = {format_code[7:4], has_blend, 1'b1};
        item.blend_size = blend_size;
        item.tex_count  = count;
        item.stride     = fixed_sum + tex_sum;
    end

endmodule

[hdl/fvld_queue.sv]
// Two-entry queue between the front and back ends.
// Depends on nothing beyond its WIDTH parameter.
module fvld_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] store_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_data = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/fvld_back.sv]
// Back end: walks the queue head item, one descriptor per cycle while the output is not
// stalled, into an output register. Depends on fvld_pkg.
module fvld_back #(
    parameter int MAX_TEX_SETS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  fvld_pkg::item_t               head_item,
    input  logic [MAX_TEX_SETS-1:0][1:0]  head_wcodes,
    output logic                          head_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    component_kind,
    output logic [2:0]                    tex_set,
    output logic [7:0]                    byte_offset,
    output logic [4:0]                    byte_size,
    output logic                          pretransformed,
    output logic [7:0]                    total_stride,
    output logic                          layout_valid,
    output logic                          last
);

    localparam int SET_W = (MAX_TEX_SETS > 1) ? $clog2(MAX_TEX_SETS) : 1;

    // Walk position within the head item
    logic [fvld_pkg::NUM_FIXED-1:0] done_reg;
    logic [fvld_pkg::NUM_FIXED-1:0] done_next;
    logic [2:0]                     set_reg;
    logic [2:0]                     set_next;
    logic [7:0]                     off_reg;
    logic [7:0]                     off_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // Output beat registers
    logic [2:0] kind_reg;
    logic [2:0] set_out_reg;
    logic [7:0] off_out_reg;
    logic [4:0] size_reg;
    logic       pre_reg;
    logic [7:0] stride_reg;
    logic       valid_out_reg;
    logic       last_reg;

    logic                           emit;
    logic [fvld_pkg::NUM_FIXED-1:0] remain;
    logic [fvld_pkg::NUM_FIXED-1:0] pick;
    logic                           found;
    logic [2:0]                     d_kind;
    logic [2:0]                     d_set;
    logic [4:0]                     d_size;
    logic                           d_last;
    logic [1:0]                     wcode;

    assign emit     = head_valid && (!out_valid_reg || out_ready);
    assign head_pop = emit && d_last;

    // Lowest fixed component still to go
    always_comb
    begin
        remain = head_item.mask & ~done_reg;
        pick   = '0;
        found  = 1'b0;
        d_kind = fvld_pkg::KIND_TEX;
        for (int i = 0; i < fvld_pkg::NUM_FIXED; i++)
        begin
            if (remain[i] && !found)
            begin
                found   = 1'b1;
                pick[i] = 1'b1;
                d_kind  = 3'(i);
            end
        end
    end

    // Descriptor for this beat
    always_comb
    begin
        wcode = head_wcodes[set_reg[SET_W-1:0]];
        d_set = 3'd0;
        if (head_item.reject)
        begin
            d_size = 5'd0;
            d_last = 1'b1;
        end
        else if (found)
        begin
            unique case (d_kind)
                fvld_pkg::KIND_POS:    d_size = head_item.pre ? fvld_pkg::SIZE_XYZRHW
                                                              : fvld_pkg::SIZE_XYZ;
                fvld_pkg::KIND_BLEND:  d_size = head_item.blend_size;
                fvld_pkg::KIND_NORMAL: d_size = fvld_pkg::SIZE_NORMAL;
                default:               d_size = fvld_pkg::SIZE_SCALAR;
            endcase
            d_last = ((remain & ~pick) == '0) && (head_item.tex_count == 4'd0);
        end
        else
        begin
            d_set  = set_reg;
            d_size = fvld_pkg::tex_bytes(wcode);
            d_last = ({1'b0, set_reg} == (head_item.tex_count - 4'd1));
        end
    end

    // Walk state next values
    always_comb
    begin
        done_next      = done_reg;
        set_next       = set_reg;
        off_next       = off_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (d_last)
            begin
                done_next = '0;
                set_next  = 3'd0;
                off_next  = 8'd0;
            end
            else
            begin
                off_next = off_reg + 8'(d_size);
                if (found)
                begin
                    done_next = done_reg | pick;
                end
                else
                begin
                    set_next = set_reg + 3'd1;
                end
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            set_reg       <= 3'd0;
            off_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            set_reg       <= set_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output beat payload; a reject beat is all zero but last
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (head_item.reject)
            begin
                kind_reg      <= fvld_pkg::KIND_POS;
                set_out_reg   <= 3'd0;
                off_out_reg   <= 8'd0;
                size_reg      <= 5'd0;
                pre_reg       <= 1'b0;
                stride_reg    <= 8'd0;
                valid_out_reg <= 1'b0;
            end
            else
            begin
                kind_reg      <= d_kind;
                set_out_reg   <= d_set;
                off_out_reg   <= off_reg;
                size_reg      <= d_size;
                pre_reg       <= head_item.pre;
                stride_reg    <= head_item.stride;
                valid_out_reg <= 1'b1;
            end
            last_reg <= d_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign component_kind = kind_reg;
    assign tex_set        = set_out_reg;
    assign byte_offset    = off_out_reg;
    assign byte_size      = size_reg;
    assign pretransformed = pre_reg;
    assign total_stride   = stride_reg;
    assign layout_valid   = valid_out_reg;
    assign last           = last_reg;

endmodule

[hdl/vertex_format_layout_decoder.sv]
// Top level of the vertex format layout decoder: front end, queue, back end.
// Depends on fvld_pkg, fvld_front, fvld_queue and fvld_back.
//
//  Channel  Handshake             Beat contents
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_ready   format_code: one vertex format code
//  out      out_valid / out_ready one component descriptor, last on final one
//
// Each code gives 1 to 14 descriptors, one descriptor per cycle while the receiver
// does not stall; consecutive codes follow with no gap.
// The front end classifies a code in the cycle it is taken and accepts a new one
// whenever the two-entry queue has room, also while the back end is stalled.
// Reset clears the queue and the walk state; no clearing pass is needed.
module vertex_format_layout_decoder #(
    parameter int MAX_TEX_SETS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] format_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  component_kind,
    output logic [2:0]  tex_set,
    output logic [7:0]  byte_offset,
    output logic [4:0]  byte_size,
    output logic        pretransformed,
    output logic [7:0]  total_stride,
    output logic        layout_valid,
    output logic        last
);

    localparam int ITEM_W  = $bits(fvld_pkg::item_t);
    localparam int QUEUE_W = ITEM_W + 2 * MAX_TEX_SETS;

    fvld_pkg::item_t                 front_item;
    logic [MAX_TEX_SETS-1:0][1:0]    front_wcodes;
    fvld_pkg::item_t                 head_item;
    logic [MAX_TEX_SETS-1:0][1:0]    head_wcodes;
    logic [QUEUE_W-1:0]              head_data;
    logic                            q_full;
    logic                            q_not_empty;
    logic                            q_pop;
    logic                            q_push;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Classification
    fvld_front #(
        .MAX_TEX_SETS (MAX_TEX_SETS)
    ) u_front (
        .format_code (format_code),
        .item        (front_item),
        .tex_wcodes  (front_wcodes)
    );

    // Decoupling queue
    fvld_queue #(
        .WIDTH (QUEUE_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_wcodes, front_item}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    assign head_item   = fvld_pkg::item_t'(head_data[ITEM_W-1:0]);
    assign head_wcodes = head_data[QUEUE_W-1:ITEM_W];

    // Descriptor generation
    fvld_back #(
        .MAX_TEX_SETS (MAX_TEX_SETS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_not_empty),
        .head_item      (head_item),
        .head_wcodes    (head_wcodes),
        .head_pop       (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .component_kind (component_kind),
        .tex_set        (tex_set),
        .byte_offset    (byte_offset),
        .byte_size      (byte_size),
        .pretransformed (pretransformed),
        .total_stride   (total_stride),
        .layout_valid   (layout_valid),
        .last           (last)
    );

endmodule

[tb/fvld_checker.sv]
`timescale 1ns / 100ps
// Descriptor checker for the vertex format layout decoder: watches both channels,
// predicts the descriptors of every accepted format code and compares each output beat.
// Depends on fvld_pkg for the component kind and position codes.
module fvld_checker #(
    parameter int MAX_SETS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] format_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  component_kind,
    input  logic [2:0]  tex_set,
    input  logic [7:0]  byte_offset,
    input  logic [4:0]  byte_size,
    input  logic        pretransformed,
    input  logic [7:0]  total_stride,
    input  logic        layout_valid,
    input  logic        last,
    output int unsigned error_count,
    output int unsigned pending,
    output int unsigned beat_count,
    output int unsigned reject_count
);

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] set;
        logic [7:0] offset;
        logic [4:0] size;
        logic       pre;
        logic [7:0] stride;
        logic       valid;
        logic       last;
    } layout_desc_t;

    // Bytes per texture set for width codes 0..3 (2, 3, 4, 1 floats)
    localparam logic [4:0] SET_BYTES [4] = '{5'd8, 5'd12, 5'd16, 5'd4};

    layout_desc_t expected_desc[$];
    int unsigned  mismatches;
    int unsigned  beats_seen;
    int unsigned  rejects_seen;

    function automatic layout_desc_t part_at(input logic [2:0] kind, input logic [2:0] set,
                                             input logic [7:0] offset, input logic [4:0] size);
        layout_desc_t d;
        d        = '0;
        d.kind   = kind;
        d.set    = set;
        d.offset = offset;
        d.size   = size;
        return d;
    endfunction

    // Expand one format code into its descriptors, in memory order
    task automatic predict_layout(input logic [31:0] code);
        layout_desc_t parts[$];
        layout_desc_t d;
        logic [2:0]   pos_code;
        logic [3:0]   set_count;
        logic [4:0]   sz;
        logic [7:0]   cursor;
        logic         rhw;
        int           s;
        int           b;
        pos_code  = code[3:1];
        set_count = code[11:8];
        rhw       = (pos_code == fvld_pkg::POS_XYZRHW);
        // no position, normal with screen-space position, or too many sets
        if (pos_code == fvld_pkg::POS_NONE || (rhw && code[4]) || set_count > MAX_SETS) begin
            d      = '0;
            d.last = 1'b1;
            expected_desc.push_back(d);
            return;
        end
        cursor = 8'd0;
        sz     = rhw ? 5'd16 : 5'd12;
        parts.push_back(part_at(fvld_pkg::KIND_POS, 3'd0, cursor, sz));
        cursor = cursor + 8'(sz);
        if (pos_code >= fvld_pkg::POS_XYZB1) begin
            sz = 5'((int'(pos_code) - 2) * 4);
            parts.push_back(part_at(fvld_pkg::KIND_BLEND, 3'd0, cursor, sz));
            cursor = cursor + 8'(sz);
        end
        // normal, point size, diffuse, specular on bits 4..7
        for (b = 0; b < 4; b++) begin
            if (code[4 + b]) begin
                sz = (b == 0) ? 5'd12 : 5'd4;
                parts.push_back(part_at(3'(fvld_pkg::KIND_NORMAL + b), 3'd0, cursor, sz));
                cursor = cursor + 8'(sz);
            end
        end
        for (s = 0; s < int'(set_count); s++) begin
            sz = SET_BYTES[code[16 + 2 * s +: 2]];
            parts.push_back(part_at(fvld_pkg::KIND_TEX, 3'(s), cursor, sz));
            cursor = cursor + 8'(sz);
        end
        foreach (parts[i]) begin
            d        = parts[i];
            d.pre    = rhw;
            d.stride = cursor;
            d.valid  = 1'b1;
            d.last   = (i == parts.size() - 1);
            expected_desc.push_back(d);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        layout_desc_t want;
        beats_seen++;
        if (!layout_valid)
            rejects_seen++;
        if (expected_desc.size() == 0) begin
            $error("descriptor beat with nothing expected: kind %0d offset %0d",
                   component_kind, byte_offset);
            mismatches++;
            return;
        end
        want = expected_desc.pop_front();
        check_field("component_kind", want.kind, component_kind);
        check_field("tex_set", want.set, tex_set);
        check_field("byte_offset", want.offset, byte_offset);
        check_field("byte_size", want.size, byte_size);
        check_field("pretransformed", want.pre, pretransformed);
        check_field("total_stride", want.stride, total_stride);
        check_field("layout_valid", want.valid, layout_valid);
        check_field("last", want.last, last);
    endtask

    // Predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_desc.delete();
            mismatches   = 0;
            beats_seen   = 0;
            rejects_seen = 0;
            error_count  <= 0;
            pending      <= 0;
            beat_count   <= 0;
            reject_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_layout(format_code);
            if (out_valid && out_ready)
                check_beat();
            error_count  <= mismatches;
            pending      <= expected_desc.size();
            beat_count   <= beats_seen;
            reject_count <= rejects_seen;
        end
    end

endmodule

[tb/tb_vertex_format_layout_decoder.sv]
`timescale 1ns / 100ps
// Testbench top for the vertex format layout decoder: clock, reset, format code stimulus,
// receiver stalls, watchdog and verdict. Depends on fvld_checker and the decoder RTL.
module tb_vertex_format_layout_decoder;

    localparam int          TEX_SET_LIMIT  = 8;
    localparam int unsigned RANDOM_CODES   = 306;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned HOLD_AT_CODE   = 90;
    localparam int unsigned STEADY_FIRST   = 150;
    localparam int unsigned STEADY_LAST    = 200;
    localparam int unsigned DRAIN_AT_CODE  = 240;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES    = 20;

    // Extremes, every position kind and component, and each reject case
    localparam int unsigned NUM_DIRECTED = 24;
    localparam logic [31:0] DIRECTED [NUM_DIRECTED] = '{
        32'h0000_0000,  // no position
        32'h0000_0001,  // ignored bit only, still no position
        32'h0000_0002,  // xyz only
        32'h0000_0004,  // screen-space xyz with rhw
        32'h0000_0006,  // one blend weight
        32'h0000_0008,
        32'h0000_000A,
        32'h0000_000C,
        32'h0000_000E,  // five blend weights
        32'h0000_0012,  // normal
        32'h0000_0014,  // normal with screen-space position: reject
        32'h0000_00E4,  // screen-space with point size, diffuse, specular
        32'h0000_0022,
        32'h0000_0042,
        32'h0000_0082,
        32'h0000_0102,  // one set of two floats
        32'h1B1B_0802,  // eight sets cycling through every width code
        32'hAAAA_08FE,  // everything, widest sets: largest stride
        32'h0000_0902,  // nine sets: reject
        32'h0000_0F02,  // fifteen sets: reject
        32'hFFFF_F0FF,  // ignored high bits and bit 0 set, no sets
        32'hFFFF_FFFF,
        32'h5555_F3F3,
        32'h0000_0814   // eight sets but normal with screen-space position
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] format_code;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  component_kind;
    logic [2:0]  tex_set;
    logic [7:0]  byte_offset;
    logic [4:0]  byte_size;
    logic        pretransformed;
    logic [7:0]  total_stride;
    logic        layout_valid;
    logic        last;

    int unsigned error_count;
    int unsigned pending;
    int unsigned beat_count;
    int unsigned reject_count;
    int unsigned codes_sent;

    vertex_format_layout_decoder #(
        .MAX_TEX_SETS (TEX_SET_LIMIT)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .format_code    (format_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .component_kind (component_kind),
        .tex_set        (tex_set),
        .byte_offset    (byte_offset),
        .byte_size      (byte_size),
        .pretransformed (pretransformed),
        .total_stride   (total_stride),
        .layout_valid   (layout_valid),
        .last           (last)
    );

    fvld_checker #(
        .MAX_SETS (TEX_SET_LIMIT)
    ) layout_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .format_code    (format_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .component_kind (component_kind),
        .tex_set        (tex_set),
        .byte_offset    (byte_offset),
        .byte_size      (byte_size),
        .pretransformed (pretransformed),
        .total_stride   (total_stride),
        .layout_valid   (layout_valid),
        .last           (last),
        .error_count    (error_count),
        .pending        (pending),
        .beat_count     (beat_count),
        .reject_count   (reject_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly back to back or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly well-formed codes with random content, the rest raw noise
    function automatic logic [31:0] random_format_code();
        logic [31:0] code;
        code = $urandom;
        if ($urandom_range(0, 99) < 85)
        begin
            code[3:1]  = 3'($urandom_range(1, 7));
            code[11:8] = 4'($urandom_range(0, TEX_SET_LIMIT));
            if (code[3:1] == fvld_pkg::POS_XYZRHW && $urandom_range(0, 9) != 0)
                code[4] = 1'b0;
        end
        return code;
    endfunction

    // Hold one beat on the input until it is taken
    task automatic send_code(input logic [31:0] code);
        in_valid    <= 1'b1;
        format_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        codes_sent++;
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid    <= 1'b0;
            format_code <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Sender: reset, directed codes, random codes, drain, verdict
    initial
    begin : stimulus
        int unsigned idx;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        format_code <= '0;
        codes_sent  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_code(DIRECTED[i]);
            idle_gap(pick_gap());
        end
        wait_drained();

        for (idx = 0; idx < RANDOM_CODES; idx++)
        begin
            send_code(random_format_code());
            if (codes_sent == DRAIN_AT_CODE)
                wait_drained();
            else if (codes_sent < STEADY_FIRST || codes_sent >= STEADY_LAST)
                idle_gap(pick_gap());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d format codes (%0d directed), checked %0d descriptor beats, %0d rejects.",
                 codes_sent, NUM_DIRECTED, beat_count, reject_count);
        $display("Receiver held off %0d cycles once; input pressure and full drains exercised.",
                 LONG_HOLD);
        if (error_count == 0 && pending == 0)
            $display("** vertex_format_layout_decoder: PASSED **");
        else
            $display("** vertex_format_layout_decoder: FAILED **");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, one stretch always ready
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned run_left;
        int unsigned codes_seen;
        bit          long_hold_done;
        out_ready      <= 1'b0;
        hold_left      = 0;
        run_left       = 0;
        codes_seen     = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (in_valid && in_ready)
                codes_seen++;
            if (!long_hold_done && codes_seen >= HOLD_AT_CODE)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (run_left == 0 && hold_left == 0)
            begin
                hold_left = pick_gap();
                run_left  = $urandom_range(1, 16);
            end
            if (codes_seen >= STEADY_FIRST && codes_seen < STEADY_LAST)
                out_ready <= 1'b1;
            else if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                run_left--;
            end
        end
    end

    // Watchdog: too long with no beat on either channel
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat for %0d cycles, %0d descriptors outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("** vertex_format_layout_decoder: FAILED **");
        $finish;
    end

endmodule

[vertex_format_layout_decoder.f]
hdl/fvld_pkg.sv
hdl/fvld_front.sv
hdl/fvld_queue.sv
hdl/fvld_back.sv
hdl/vertex_format_layout_decoder.sv
tb/fvld_checker.sv
tb/tb_vertex_format_layout_decoder.sv
